/* rtl/conv2d_pkg.sv */
`default_nettype none

package conv2d_pkg;

  // default geometry, handed to the top level parameters
  localparam int CONV2D_MAX_WIDTH  = 1024;
  localparam int CONV2D_MAX_HEIGHT = 4096;
  localparam int CONV2D_PIXEL_BITS = 8;

  // configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int KROW_W       = 24;
  localparam int COEF_W       = 8;

  localparam int RST_WIDTH  = 1024;
  localparam int RST_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  // result fields
  localparam int OUT_VALUE_W = 20;
  localparam int OUT_ROW_W   = 12;
  localparam int OUT_COL_W   = 10;

  // kernel rows, top row at index 0, left coefficient in the low byte
  typedef logic [2:0][KROW_W-1:0] kernel_t;

  // position of the centre pixel carried alongside a word
  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } conv2d_pos_t;

endpackage

`default_nettype wire

/* rtl/conv2d_cfg.sv */
`default_nettype none

module conv2d_cfg
  import conv2d_pkg::*;
#(
  parameter int MAX_WIDTH  = CONV2D_MAX_WIDTH,
  parameter int MAX_HEIGHT = CONV2D_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [CFG_DATA_W-1:0]          cfg_data,
  output logic [$clog2(MAX_WIDTH)-1:0]        width_m1,
  output logic [$clog2(MAX_HEIGHT)-1:0]       height_m1,
  output kernel_t                             kernel
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int W_RST = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int H_RST = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

  logic [CW-1:0]           width_m1_r, width_m1_nxt;
  logic [RW-1:0]           height_m1_r, height_m1_nxt;
  kernel_t                 kernel_r;
  logic [CFG_WIDTH_W-1:0]  wdat;
  logic [CFG_HEIGHT_W-1:0] hdat;

  assign cfg_ready = 1'b1;
  assign wdat      = cfg_data[CFG_WIDTH_W-1:0];
  assign hdat      = cfg_data[CFG_HEIGHT_W-1:0];

  // sizes are clamped once on write and kept as size minus one
  always_comb begin
    priority if (32'(wdat) < 32'd3) begin
      width_m1_nxt = CW'(2);
    end else if (32'(wdat) > 32'(MAX_WIDTH)) begin
      width_m1_nxt = CW'(MAX_WIDTH - 1);
    end else begin
      width_m1_nxt = CW'(wdat - 1'b1);
    end
    priority if (32'(hdat) < 32'd3) begin
      height_m1_nxt = RW'(2);
    end else if (32'(hdat) > 32'(MAX_HEIGHT)) begin
      height_m1_nxt = RW'(MAX_HEIGHT - 1);
    end else begin
      height_m1_nxt = RW'(hdat - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_m1_r  <= CW'(W_RST - 1);
      height_m1_r <= RW'(H_RST - 1);
      kernel_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   width_m1_r  <= width_m1_nxt;
        REG_IMAGE_HEIGHT:  height_m1_r <= height_m1_nxt;
        REG_KERNEL_TOP:    kernel_r[0] <= cfg_data[KROW_W-1:0];
        REG_KERNEL_MIDDLE: kernel_r[1] <= cfg_data[KROW_W-1:0];
        REG_KERNEL_BOTTOM: kernel_r[2] <= cfg_data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_m1  = width_m1_r;
  assign height_m1 = height_m1_r;
  assign kernel    = kernel_r;

endmodule

`default_nettype wire

/* rtl/conv2d_linebuf.sv */
`default_nettype none

module conv2d_linebuf
  import conv2d_pkg::*;
#(
  parameter int MAX_WIDTH  = CONV2D_MAX_WIDTH,
  parameter int MAX_HEIGHT = CONV2D_MAX_HEIGHT,
  parameter int PIXEL_BITS = CONV2D_PIXEL_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [PIXEL_BITS-1:0]         in_pixel,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  width_m1,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] height_m1,
  input  wire logic                          s1_take,
  output logic                               s1_valid,
  output logic                               s1_produce,
  output conv2d_pos_t                        s1_pos,
  output logic [PIXEL_BITS-1:0]              s1_pixel,
  output logic [PIXEL_BITS-1:0]              s1_top,
  output logic [PIXEL_BITS-1:0]              s1_mid
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic                  s1_v_r;
  logic [PIXEL_BITS-1:0] pix1_r;
  logic [CW-1:0]         c1_r;
  logic                  prod1_r;
  conv2d_pos_t           pos1_r;
  logic [PIXEL_BITS-1:0] top_rd_r;
  logic [PIXEL_BITS-1:0] mid_rd_r;
  logic                  accept;
  logic                  s1_go;

  assign s1_go    = s1_v_r && s1_take;
  assign in_stall = s1_v_r && !s1_take;
  assign accept   = in_valid && !in_stall;

  // stream position of the incoming pixel
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_r >= width_m1) begin
        col_nxt = '0;
        row_nxt = (row_r >= height_m1) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1_r     <= in_pixel;
      c1_r       <= col_r;
      prod1_r    <= (row_r >= RW'(2)) && (col_r >= CW'(2));
      pos1_r.row <= OUT_ROW_W'(row_r - 1'b1);
      pos1_r.col <= OUT_COL_W'(col_r - 1'b1);
      pos1_r.last <= (row_r == height_m1) && (col_r == width_m1);
    end
  end

  // read on accept, write back once the word leaves this stage
  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd_r <= upper_mem[col_r];
    end
    if (s1_go) begin
      upper_mem[c1_r] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd_r <= lower_mem[col_r];
    end
    if (s1_go) begin
      lower_mem[c1_r] <= pix1_r;
    end
  end

  assign s1_valid   = s1_v_r;
  assign s1_produce = prod1_r;
  assign s1_pos     = pos1_r;
  assign s1_pixel   = pix1_r;
  assign s1_top     = top_rd_r;
  assign s1_mid     = mid_rd_r;

  // a new read never hits the entry being written back in the same cycle
  a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_go |-> col_r != c1_r)
    else $error("line store read and write hit the same column");

  // early rows read entries not yet written, so compare with x kept as is
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_take |=> s1_v_r && $stable(c1_r) && (top_rd_r === $past(top_rd_r)))
    else $error("held word lost its line store data");

endmodule

`default_nettype wire

/* rtl/conv2d_window.sv */
`default_nettype none

module conv2d_window
  import conv2d_pkg::*;
#(
  parameter int PIXEL_BITS = CONV2D_PIXEL_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  s1_valid,
  input  wire logic                  s1_produce,
  input  wire conv2d_pos_t           s1_pos,
  input  wire logic [PIXEL_BITS-1:0] s1_pixel,
  input  wire logic [PIXEL_BITS-1:0] s1_top,
  input  wire logic [PIXEL_BITS-1:0] s1_mid,
  output logic                       s1_take,
  input  wire logic                  s2_take,
  output logic                       s2_valid,
  output conv2d_pos_t                s2_pos,
  output logic [2:0][2:0][PIXEL_BITS-1:0] win
);

  logic [2:0][2:0][PIXEL_BITS-1:0] win_r;
  logic                            s2_v_r;
  conv2d_pos_t                     pos2_r;
  logic                            s1_go;

  assign s1_take = !s2_v_r || s2_take;
  assign s1_go   = s1_valid && s1_take;

  // window shifts on every pixel; only interior ones move on as a word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_go) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= s1_top;
        win_r[1][2] <= s1_mid;
        win_r[2][2] <= s1_pixel;
        s2_v_r      <= s1_produce;
      end else if (s2_take) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pos2_r <= s1_pos;
    end
  end

  assign s2_valid = s2_v_r;
  assign s2_pos   = pos2_r;
  assign win      = win_r;

  a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !s2_take |=> $stable(win_r) && s2_v_r)
    else $error("window moved under a waiting word");

endmodule

`default_nettype wire

/* rtl/conv2d_mac.sv */
`default_nettype none

module conv2d_mac
  import conv2d_pkg::*;
#(
  parameter int PIXEL_BITS = CONV2D_PIXEL_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              s2_valid,
  input  wire conv2d_pos_t                       s2_pos,
  input  wire logic [2:0][2:0][PIXEL_BITS-1:0]   win,
  input  wire kernel_t                           kernel,
  output logic                                   s2_take,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [OUT_VALUE_W-1:0]          out_value,
  output logic [OUT_ROW_W-1:0]                   out_row,
  output logic [OUT_COL_W-1:0]                   out_col,
  output logic                                   out_last_in_frame
);

  localparam int PROD_W = PIXEL_BITS + COEF_W + 1;
  localparam int SUM_W  = PROD_W + 4;
  localparam int EXT_W  = (SUM_W > OUT_VALUE_W) ? SUM_W : OUT_VALUE_W;

  logic signed [PROD_W-1:0]       prod_nxt [3][3];
  logic signed [PROD_W-1:0]       prod_r   [3][3];
  conv2d_pos_t                    pos3_r;
  logic                           s3_v_r;
  logic signed [SUM_W-1:0]        sum;
  logic signed [EXT_W-1:0]        sum_ext;
  logic                           out_v_r;
  logic signed [OUT_VALUE_W-1:0]  value_r;
  conv2d_pos_t                    pos_out_r;
  logic                           out_take;
  logic                           s3_take;
  logic                           s3_go;
  logic                           s2_go;

  assign out_take = !out_v_r || !out_stall;
  assign s3_take  = !s3_v_r || out_take;
  assign s3_go    = s3_v_r && out_take;
  assign s2_take  = s3_take;
  assign s2_go    = s2_valid && s3_take;

  // pixel is unsigned, coefficient is a signed byte
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = $signed({1'b0, win[i][j]}) *
                         $signed(kernel[i][COEF_W*j +: COEF_W]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = sum + SUM_W'(prod_r[i][j]);
      end
    end
    sum_ext = EXT_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_go) begin
        s3_v_r <= 1'b1;
      end else if (s3_go) begin
        s3_v_r <= 1'b0;
      end
      if (s3_go) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      prod_r <= prod_nxt;
      pos3_r <= s2_pos;
    end
    if (s3_go) begin
      value_r   <= sum_ext[OUT_VALUE_W-1:0];
      pos_out_r <= pos3_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_value         = value_r;
  assign out_row           = pos_out_r.row;
  assign out_col           = pos_out_r.col;
  assign out_last_in_frame = pos_out_r.last;

  a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s3_v_r))
    else $error("result word appeared without a product stage word");

endmodule

`default_nettype wire

/* rtl/conv2d_3x3_stream.sv */
`default_nettype none

// Streaming 3x3 convolution. Pixels enter one word per clock unless stalled,
// in row-major order, and every interior pixel yields one signed weighted sum
// with its row, column and an end-of-frame mark; border pixels yield nothing.
// Throughput is one pixel per cycle while neither side stalls. The line store
// is read into a register at the edge that accepts a pixel, then come the
// window shift, the product register and the sum into the output register;
// the registered read and the split of multiply and sum over two stages make
// up this pipeline. Image size and kernel rows are written through the cfg
// port, which is always ready, and should only change while the stream is
// idle. Line store contents are not cleared on reset.
module conv2d_3x3_stream
  import conv2d_pkg::*;
#(
  parameter int MAX_WIDTH  = CONV2D_MAX_WIDTH,
  parameter int MAX_HEIGHT = CONV2D_MAX_HEIGHT,
  parameter int PIXEL_BITS = CONV2D_PIXEL_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [PIXEL_BITS-1:0]     in_pixel,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [OUT_VALUE_W-1:0]  out_value,
  output logic [OUT_ROW_W-1:0]           out_row,
  output logic [OUT_COL_W-1:0]           out_col,
  output logic                           out_last_in_frame,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]                   width_m1;
  logic [RW-1:0]                   height_m1;
  kernel_t                         kernel;
  logic                            s1_take;
  logic                            s1_valid;
  logic                            s1_produce;
  conv2d_pos_t                     s1_pos;
  logic [PIXEL_BITS-1:0]           s1_pixel;
  logic [PIXEL_BITS-1:0]           s1_top;
  logic [PIXEL_BITS-1:0]           s1_mid;
  logic                            s2_take;
  logic                            s2_valid;
  conv2d_pos_t                     s2_pos;
  logic [2:0][2:0][PIXEL_BITS-1:0] win;

  conv2d_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .kernel    (kernel)
  );

  conv2d_linebuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_linebuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel   (in_pixel),
    .width_m1   (width_m1),
    .height_m1  (height_m1),
    .s1_take    (s1_take),
    .s1_valid   (s1_valid),
    .s1_produce (s1_produce),
    .s1_pos     (s1_pos),
    .s1_pixel   (s1_pixel),
    .s1_top     (s1_top),
    .s1_mid     (s1_mid)
  );

  conv2d_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_produce (s1_produce),
    .s1_pos     (s1_pos),
    .s1_pixel   (s1_pixel),
    .s1_top     (s1_top),
    .s1_mid     (s1_mid),
    .s1_take    (s1_take),
    .s2_take    (s2_take),
    .s2_valid   (s2_valid),
    .s2_pos     (s2_pos),
    .win        (win)
  );

  conv2d_mac #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mac (
    .clk               (clk),
    .rst_n             (rst_n),
    .s2_valid          (s2_valid),
    .s2_pos            (s2_pos),
    .win               (win),
    .kernel            (kernel),
    .s2_take           (s2_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_in_frame (out_last_in_frame)
  );

endmodule

`default_nettype wire

/* tb/tb_conv2d_3x3_stream.sv */
module tb_conv2d_3x3_stream;
  import conv2d_pkg::*;

  localparam int MAX_W       = CONV2D_MAX_WIDTH;
  localparam int MAX_H       = CONV2D_MAX_HEIGHT;
  localparam int PX_W        = CONV2D_PIXEL_BITS;
  localparam int PIPE_DELAY  = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic signed [OUT_VALUE_W-1:0] value;
    logic [OUT_ROW_W-1:0]          row;
    logic [OUT_COL_W-1:0]          col;
    logic                          last;
  } conv_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [PX_W-1:0]               in_pixel = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [OUT_VALUE_W-1:0] out_value;
  logic [OUT_ROW_W-1:0]          out_row;
  logic [OUT_COL_W-1:0]          out_col;
  logic                          out_last_in_frame;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  // shadow of the block: registers, line stores, window and stream position
  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;
  kernel_t                 kernel_rows;
  logic [PX_W-1:0]         upper_line [MAX_W];
  logic [PX_W-1:0]         lower_line [MAX_W];
  logic [PX_W-1:0]         win [3][3];
  int unsigned             col_pos;
  int unsigned             row_pos;
  conv_result_t            pending_sums [$];
  conv_result_t            head;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int fail_count    = 0;
  int pixels_sent   = 0;
  int sums_checked  = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;

  conv2d_3x3_stream u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_in_frame (out_last_in_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: word with no sum pending: value %0d row %0d col %0d",
                 $time, out_value, out_row, out_col);
        fail_count++;
      end else begin
        head = pending_sums.pop_front();
        sums_checked++;
        if (out_value !== head.value) begin
          $display("%0t: value expected %0d, got %0d", $time, $signed(head.value), out_value);
          fail_count++;
        end
        if (out_row !== head.row) begin
          $display("%0t: row expected %0d, got %0d", $time, head.row, out_row);
          fail_count++;
        end
        if (out_col !== head.col) begin
          $display("%0t: col expected %0d, got %0d", $time, head.col, out_col);
          fail_count++;
        end
        if (out_last_in_frame !== head.last) begin
          $display("%0t: last_in_frame expected %0b, got %0b", $time, head.last,
                   out_last_in_frame);
          fail_count++;
        end
      end
    end
  end

  function automatic void convolve_pixel(input logic [PX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int acc;
    logic signed [COEF_W-1:0] k;
    conv_result_t res;
    w = (width_reg < 3) ? 3 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg < 3) ? 3 : (height_reg > MAX_H) ? MAX_H : height_reg;
    c = col_pos % MAX_W;
    r = row_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = lower_line[c];
    win[2][2] = px;
    upper_line[c] = lower_line[c];
    lower_line[c] = px;
    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          k = kernel_rows[i][COEF_W*j +: COEF_W];
          acc += int'(win[i][j]) * int'(k);
        end
      end
      res.value = acc[OUT_VALUE_W-1:0];
      res.row   = OUT_ROW_W'(r - 1);
      res.col   = OUT_COL_W'(c - 1);
      res.last  = (r == h - 1) && (c == w - 1);
      pending_sums.push_back(res);
    end
    // a position beyond a shrunken size still wraps after this pixel
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic logic [PX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PX_W'($urandom());
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] random_kernel_row();
    logic [KROW_W-1:0] row;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(5))
        0: row[COEF_W*j +: COEF_W] = 8'h80;
        1: row[COEF_W*j +: COEF_W] = 8'h7f;
        default: row[COEF_W*j +: COEF_W] = COEF_W'($urandom());
      endcase
    end
    return row;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg = val[CFG_WIDTH_W-1:0];
      REG_IMAGE_HEIGHT:  height_reg = val[CFG_HEIGHT_W-1:0];
      REG_KERNEL_TOP:    kernel_rows[0] = val[KROW_W-1:0];
      REG_KERNEL_MIDDLE: kernel_rows[1] = val[KROW_W-1:0];
      REG_KERNEL_BOTTOM: kernel_rows[2] = val[KROW_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h,
                           input logic [KROW_W-1:0] k_top, input logic [KROW_W-1:0] k_mid,
                           input logic [KROW_W-1:0] k_bot);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_KERNEL_TOP, k_top);
    write_reg(REG_KERNEL_MIDDLE, k_mid);
    write_reg(REG_KERNEL_BOTTOM, k_bot);
  endtask

  // valid stays high across back-to-back words; it only drops for a gap
  task automatic send_pixel(input logic [PX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    convolve_pixel(px);
    pixels_sent++;
  endtask

  // sends a whole frame from the frame start, or the rest of a started one
  task automatic run_to_frame_end();
    do send_pixel(random_pixel()); while (col_pos != 0 || row_pos != 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DELAY) @(posedge clk);
  endtask

  // part of a first row at the reset size, then a shrink to 3x3 ends the
  // frame; the kernel keeps its reset value, so all sums are zero
  task automatic test_reset_defaults();
    repeat (40) send_pixel(random_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    run_to_frame_end();
    settle();
  endtask

  // undersized settings clamp to 3x3; most negative and most positive sums
  task automatic test_field_extremes();
    set_frame(0, 1, 24'h808080, 24'h808080, 24'h808080);
    repeat (9) send_pixel('1);
    settle();
    set_frame(1, 2, 24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f);
    repeat (9) send_pixel('1);
    settle();
    set_frame(2, 3, 24'h7f807f, 24'h80017f, 24'h00ff80);
    for (int n = 0; n < 9; n++) send_pixel(n[0] ? '1 : '0);
    settle();
  endtask

  // shrink width, then height, while the position lies beyond the new size
  task automatic test_midframe_resize();
    set_frame(8, 6, random_kernel_row(), random_kernel_row(), random_kernel_row());
    while (row_pos != 2 || col_pos != 6) send_pixel(random_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
    while (row_pos != 3 || col_pos != 2) send_pixel(random_pixel());
    settle();
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    run_to_frame_end();
    settle();
  endtask

  // long output hold-off while pixels keep coming, so the input backs up
  task automatic test_backpressure();
    set_frame(10, 6, random_kernel_row(), random_kernel_row(), random_kernel_row());
    hold_left = HOLD_CYCLES;
    run_to_frame_end();
    settle();
  endtask

  task automatic test_random_frames(input int target);
    int start_count;
    int unsigned w;
    int unsigned h;
    start_count = pixels_sent;
    while (pixels_sent - start_count < target) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      set_frame(w, h, random_kernel_row(), random_kernel_row(), random_kernel_row());
      if ($urandom_range(5) == 0) begin
        // break off partway, shrink the frame and swap a kernel row
        repeat ($urandom_range(1, w * h - 1)) send_pixel(random_pixel());
        settle();
        if ($urandom_range(1) == 0)
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(3, w)));
        else
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(3, h)));
        write_reg(REG_KERNEL_MIDDLE, random_kernel_row());
      end
      run_to_frame_end();
      settle();
    end
  endtask

  // oversized settings clamp to the widest row and the tallest frame; part
  // of a row or frame on each, then a shrink closes it
  task automatic test_size_extremes();
    set_frame(2047, 3, random_kernel_row(), random_kernel_row(), random_kernel_row());
    repeat (30) send_pixel(random_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
    run_to_frame_end();
    settle();
    set_frame(3, 8191, random_kernel_row(), random_kernel_row(), random_kernel_row());
    repeat (45) send_pixel(random_pixel());
    settle();
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(16));
    run_to_frame_end();
    settle();
  endtask

  initial begin
    width_reg   = CFG_WIDTH_W'(RST_WIDTH);
    height_reg  = CFG_HEIGHT_W'(RST_HEIGHT);
    kernel_rows = '0;
    col_pos     = 0;
    row_pos     = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    send_idle_pct = 32;
    recv_idle_pct = 45;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_midframe_resize();
    test_random_frames(190);

    send_idle_pct = 45;
    recv_idle_pct = 32;
    test_backpressure();
    test_random_frames(190);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(190);
    test_size_extremes();

    $display("%0d pixels in, %0d sums checked, %0d register writes", pixels_sent,
             sums_checked, reg_writes);
    $display("frames from 3x3 up to 48 wide, clamped sizes, mid-frame shrinks, output hold-off");
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
